>>> rtl/sorted_table_membership_search_core_macros.svh
// Assertion macros shared by the sorted table membership search RTL.
`ifndef SORTED_TABLE_MEMBERSHIP_SEARCH_CORE_MACROS_SVH
`define SORTED_TABLE_MEMBERSHIP_SEARCH_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Check cons in the same cycle as ante.
`define STSC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Check cons in the cycle after ante.
`define STSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define STSC_ASSERT_NOW(label, clk, rst, ante, cons)
`define STSC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/stsc_pkg.sv
// Package: types and constants of the sorted table membership search core.
`timescale 1ns / 1ps
package stsc_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);
   localparam int ENTRIES_W   = 9;
   localparam int HITS_W      = 16;
   localparam int VALUE_W     = 32;

   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_QUERY = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef struct packed {
      logic [1:0]                op;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic                 found;
      logic [HITS_W-1:0]    hits;
      logic [ENTRIES_W-1:0] entries;
      logic                 status;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SRCH   = 5'b00010,
      ST_INS    = 5'b00100,
      ST_INS_WR = 5'b01000,
      ST_DONE   = 5'b10000
   } state_type;

endpackage

>>> rtl/sorted_table_membership_search_core.sv
// Sorted table membership search core: sorted insert and binary search in one memory.
//
// Usage
//  - Request channel (req_valid / req_stall / req_data): op LOAD inserts value at its
//    sorted place, QUERY searches for value, CLEAR empties the table and zeroes the hit
//    count. Op code three changes nothing and reports the current counts.
//  - Response channel (rsp_valid / rsp_stall / rsp_data): exactly one response per
//    request, in request order: found flag, saturating hit count, entry count, status.
//  - One request is in flight at a time. A query reads one probe after another until
//    it matches or the window closes; a load shifts each larger entry up one slot.
//    Clear, a full load, op three and a load into an empty table need neither.
//    The response becomes valid in the same cycle as the next request can be taken.
//    The pace is set by the single read port of the table memory: one probe or one
//    shift step per cycle, each compare working on the registered read data.
//  - Reset (synchronous, active high) empties the table and clears the hit count;
//    the memory itself is not cleared, as only filled slots are ever read.
//  - A stalled response is held in its output register; the core may take the next
//    request meanwhile and parks its result until the output register frees up.
`timescale 1ns / 1ps
`include "sorted_table_membership_search_core_macros.svh"
module sorted_table_membership_search_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  stsc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output stsc_pkg::rsp_type rsp_data
);

   // Table storage: one write port, one registered read port.
   logic signed [stsc_pkg::VALUE_W-1:0] table_mem [stsc_pkg::TABLE_DEPTH];
   logic signed [stsc_pkg::VALUE_W-1:0] rd_data_ff;

   logic                                mem_we;
   logic [stsc_pkg::ADDR_W-1:0]         mem_waddr;
   logic signed [stsc_pkg::VALUE_W-1:0] mem_wdata;
   logic                                mem_re;
   logic [stsc_pkg::ADDR_W-1:0]         mem_raddr;

   // Control and working registers.
   stsc_pkg::state_type                 state_ff, state_in;
   logic [stsc_pkg::COUNT_W-1:0]        count_ff, count_in;
   logic [stsc_pkg::HITS_W-1:0]         hits_ff, hits_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   stsc_pkg::rsp_type                   rsp_ff, rsp_in;

   logic [stsc_pkg::COUNT_W-1:0]        left_ff, left_in;
   logic [stsc_pkg::COUNT_W-1:0]        right_ff, right_in;
   logic [stsc_pkg::ADDR_W-1:0]         mid_ff, mid_in;
   logic [stsc_pkg::COUNT_W-1:0]        slot_ff, slot_in;
   logic signed [stsc_pkg::VALUE_W-1:0] key_ff, key_in;
   logic                                found_ff, found_in;
   logic                                status_ff, status_in;

   // Search and insert helpers.
   logic                                req_accept;
   logic                                table_full;
   logic                                load_dropped;
   logic [stsc_pkg::COUNT_W-1:0]        next_left;
   logic [stsc_pkg::COUNT_W-1:0]        next_right;
   logic [stsc_pkg::COUNT_W-1:0]        next_mid;
   logic [stsc_pkg::COUNT_W-1:0]        first_mid;
   logic [stsc_pkg::COUNT_W-1:0]        count_m1;
   logic [stsc_pkg::COUNT_W-1:0]        slot_m1;
   logic [stsc_pkg::COUNT_W-1:0]        slot_m2;
   logic [stsc_pkg::COUNT_W-1:0]        mid_wide;

   assign req_stall  = (state_ff != stsc_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign table_full = (count_ff >= stsc_pkg::COUNT_W'(stsc_pkg::TABLE_DEPTH));
   assign load_dropped = req_accept && (req_data.op == stsc_pkg::OP_LOAD) && table_full;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign mid_wide  = stsc_pkg::COUNT_W'(mid_ff);
   assign first_mid = count_ff >> 1;
   assign count_m1  = count_ff - stsc_pkg::COUNT_W'(1);
   assign slot_m1   = slot_ff - stsc_pkg::COUNT_W'(1);
   assign slot_m2   = slot_ff - stsc_pkg::COUNT_W'(2);

   // Narrow the search window around the probe just read.
   always_comb begin
      if (key_ff > rd_data_ff) begin
         next_left  = mid_wide + stsc_pkg::COUNT_W'(1);
         next_right = right_ff;
      end else begin
         next_left  = left_ff;
         next_right = mid_wide;
      end
      next_mid = next_left + ((next_right - next_left) >> 1);
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      hits_in      = hits_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      mid_in       = mid_ff;
      slot_in      = slot_ff;
      key_in       = key_ff;
      found_in     = found_ff;
      status_in    = status_ff;
      mem_we       = 1'b0;
      mem_waddr    = slot_ff[stsc_pkg::ADDR_W-1:0];
      mem_wdata    = key_ff;
      mem_re       = 1'b0;
      mem_raddr    = mid_ff;

      unique case (state_ff)
         stsc_pkg::ST_IDLE: begin
            if (req_accept) begin
               key_in    = req_data.value;
               found_in  = 1'b0;
               status_in = stsc_pkg::STATUS_OK;
               state_in  = stsc_pkg::ST_DONE;
               unique case (req_data.op)
                  stsc_pkg::OP_LOAD: begin
                     if (table_full) begin
                        // Drop the load and flag it.
                        status_in = stsc_pkg::STATUS_FULL;
                     end else if (count_ff == '0) begin
                        // Empty table: the value goes straight to the bottom slot.
                        mem_we    = 1'b1;
                        mem_waddr = '0;
                        mem_wdata = req_data.value;
                        count_in  = count_ff + stsc_pkg::COUNT_W'(1);
                     end else begin
                        // Start the shift from the top entry downwards.
                        slot_in   = count_ff;
                        mem_re    = 1'b1;
                        mem_raddr = count_m1[stsc_pkg::ADDR_W-1:0];
                        state_in  = stsc_pkg::ST_INS;
                     end
                  end
                  stsc_pkg::OP_QUERY: begin
                     if (count_ff != '0) begin
                        left_in   = '0;
                        right_in  = count_ff;
                        mid_in    = first_mid[stsc_pkg::ADDR_W-1:0];
                        mem_re    = 1'b1;
                        mem_raddr = first_mid[stsc_pkg::ADDR_W-1:0];
                        state_in  = stsc_pkg::ST_SRCH;
                     end
                  end
                  stsc_pkg::OP_CLEAR: begin
                     count_in = '0;
                     hits_in  = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end

         stsc_pkg::ST_SRCH: begin
            // One probe per cycle: compare the registered read, issue the next read.
            if (key_ff == rd_data_ff) begin
               found_in = 1'b1;
               if (hits_ff != '1) begin
                  hits_in = hits_ff + stsc_pkg::HITS_W'(1);
               end
               state_in = stsc_pkg::ST_DONE;
            end else if (next_left < next_right) begin
               left_in   = next_left;
               right_in  = next_right;
               mid_in    = next_mid[stsc_pkg::ADDR_W-1:0];
               mem_re    = 1'b1;
               mem_raddr = next_mid[stsc_pkg::ADDR_W-1:0];
            end else begin
               state_in = stsc_pkg::ST_DONE;
            end
         end

         stsc_pkg::ST_INS: begin
            // rd_data_ff holds the entry just below slot_ff. Reads only move
            // downwards, so a read never meets a slot written by this load.
            mem_we    = 1'b1;
            mem_waddr = slot_ff[stsc_pkg::ADDR_W-1:0];
            if (key_ff < rd_data_ff) begin
               mem_wdata = rd_data_ff;
               slot_in   = slot_m1;
               if (slot_m1 != '0) begin
                  mem_re    = 1'b1;
                  mem_raddr = slot_m2[stsc_pkg::ADDR_W-1:0];
               end else begin
                  state_in = stsc_pkg::ST_INS_WR;
               end
            end else begin
               mem_wdata = key_ff;
               count_in  = count_ff + stsc_pkg::COUNT_W'(1);
               state_in  = stsc_pkg::ST_DONE;
            end
         end

         stsc_pkg::ST_INS_WR: begin
            // Every held entry was larger: place the value in the bottom slot.
            mem_we    = 1'b1;
            mem_waddr = slot_ff[stsc_pkg::ADDR_W-1:0];
            mem_wdata = key_ff;
            count_in  = count_ff + stsc_pkg::COUNT_W'(1);
            state_in  = stsc_pkg::ST_DONE;
         end

         stsc_pkg::ST_DONE: begin
            // Hand the result over once the output register is free.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_in.found   = found_ff;
               rsp_in.hits    = hits_ff;
               rsp_in.entries = stsc_pkg::ENTRIES_W'(count_ff);
               rsp_in.status  = status_ff;
               state_in       = stsc_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = stsc_pkg::ST_IDLE;
         end
      endcase
   end

   // Table memory.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= table_mem[mem_raddr];
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= stsc_pkg::ST_IDLE;
         count_ff     <= '0;
         hits_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         hits_ff      <= hits_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and payload registers.
   always_ff @(posedge clock) begin
      rsp_ff    <= rsp_in;
      left_ff   <= left_in;
      right_ff  <= right_in;
      mid_ff    <= mid_in;
      slot_ff   <= slot_in;
      key_ff    <= key_in;
      found_ff  <= found_in;
      status_ff <= status_in;
   end

   `STSC_ASSERT_NOW(a_count_in_range, clock, reset, 1'b1, !(count_ff > count_m1 + 9'd1))
   `STSC_ASSERT_NOW(a_search_window_open, clock, reset, state_ff == stsc_pkg::ST_SRCH, left_ff < right_ff)
   `STSC_ASSERT_NOW(a_no_same_slot_rw, clock, reset, mem_we && mem_re, mem_waddr != mem_raddr)
   `STSC_ASSERT_NEXT(a_full_load_dropped, clock, reset, load_dropped, count_ff == $past(count_ff))

endmodule

>>> tb/stsc_response_checker.sv
// Response checker for the sorted table search core: predicts each response and compares it.
`timescale 1ns / 1ps
module stsc_response_checker
   import stsc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending
);

   // Own copy of the table, kept in ascending signed order.
   logic signed [VALUE_W-1:0] held_values [TABLE_DEPTH];
   int unsigned               held_count = 0;
   logic [HITS_W-1:0]         hit_total  = '0;
   rsp_type                   outcome_q [$];
   int                        mismatches = 0;

   // Apply one request to the table copy and return the response it must give.
   function automatic rsp_type table_outcome(input req_type item);
      rsp_type                   outcome;
      logic signed [VALUE_W-1:0] key;
      int unsigned               slot;
      outcome        = '0;
      outcome.status = STATUS_OK;
      key            = item.value;
      case (item.op)
         OP_LOAD: begin
            if (held_count >= TABLE_DEPTH) begin
               outcome.status = STATUS_FULL;
            end else begin
               // Shift strictly greater entries up; equal values keep arrival order.
               slot = held_count;
               while (slot > 0 && key < held_values[slot-1]) begin
                  held_values[slot] = held_values[slot-1];
                  slot--;
               end
               held_values[slot] = key;
               held_count++;
            end
         end
         OP_QUERY: begin
            for (int i = 0; i < held_count; i++) begin
               if (held_values[i] == key) outcome.found = 1'b1;
            end
            if (outcome.found && hit_total != '1) hit_total++;
         end
         OP_CLEAR: begin
            held_count = 0;
            hit_total  = '0;
         end
         default: begin
         end
      endcase
      outcome.hits    = hit_total;
      outcome.entries = held_count[ENTRIES_W-1:0];
      return outcome;
   endfunction

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want !== got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         outcome_q.delete();
         held_count = 0;
         hit_total  = '0;
      end else begin
         // Take the response first: the request of this edge cannot answer yet.
         if (rsp_valid && !rsp_stall) begin
            if (outcome_q.size() == 0) begin
               $error("response with none expected: found %0d hits %0d entries %0d status %0d",
                      rsp_data.found, rsp_data.hits, rsp_data.entries, rsp_data.status);
               mismatches++;
            end else begin
               want = outcome_q.pop_front();
               check_field("found",   want.found,   rsp_data.found);
               check_field("hits",    want.hits,    rsp_data.hits);
               check_field("entries", want.entries, rsp_data.entries);
               check_field("status",  want.status,  rsp_data.status);
            end
         end
         if (req_valid && !req_stall) outcome_q.push_back(table_outcome(req_data));
      end
      pending    <= outcome_q.size();
      fail_count <= mismatches;
   end

endmodule

>>> tb/sorted_table_membership_search_core_tb.sv
// Testbench top for the sorted table membership search core: stimulus, idling and verdict.
`timescale 1ns / 1ps
module sorted_table_membership_search_core_tb;
   import stsc_pkg::*;

   // Op code three has no name in the package; the core must ignore it.
   localparam logic [1:0] OP_SPARE = 2'd3;

   localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
   localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

   localparam int RANDOM_REQUESTS = 830;
   // Long receiver hold-off: far more than a full load needs, so the core backs up.
   localparam int PRESSURE_CYCLES = 400;
   // A load into a nearly full table shifts up to depth - 1 entries; leave room for it and more.
   localparam int DRAIN_CYCLES    = 2 * TABLE_DEPTH + 50;

   typedef enum int {
      IDLE_SENDER_LIGHT,
      IDLE_SENDER_HEAVY,
      IDLE_NONE
   } idle_mode_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;
   int      fail_count;
   int      pending;

   idle_mode_type             idle_mode = IDLE_SENDER_LIGHT;
   int                        requests_sent = 0;
   // Values loaded since the last clear; used to aim queries at real entries.
   logic signed [VALUE_W-1:0] loaded_values [$];

   sorted_table_membership_search_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   stsc_response_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Watchdog: the slowest correct run, every request at its longest plus stalls,
   // stays well under this limit; reaching it reports a failure.
   initial begin
      #20_000_000;
      $display("sorted_table_membership_search_core_tb: FAIL");
      $finish;
   end

   function automatic int sender_idle_pct();
      case (idle_mode)
         IDLE_SENDER_LIGHT: return 24;
         IDLE_SENDER_HEAVY: return 56;
         default:           return 0;
      endcase
   endfunction

   function automatic int receiver_idle_pct();
      case (idle_mode)
         IDLE_SENDER_LIGHT: return 56;
         IDLE_SENDER_HEAVY: return 24;
         default:           return 0;
      endcase
   endfunction

   // Receiver: decide on the rising edge, drive on the falling one. The first time
   // the idle mode drops to none, hold off for a long stretch so the core fills up.
   initial begin
      int   hold_left;
      bit   hold_done;
      logic stall_next;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (idle_mode == IDLE_NONE && !hold_done) begin
            hold_left = PRESSURE_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            stall_next = 1'b1;
            hold_left--;
         end else begin
            stall_next = ($urandom_range(99) < receiver_idle_pct());
         end
         @(negedge clock);
         rsp_stall <= stall_next;
      end
   end

   // Offer one request, idling first at random; return on the falling edge after
   // acceptance so the next request follows without lowering valid.
   task automatic send_request(input logic [1:0] op, input logic signed [VALUE_W-1:0] value);
      req_type item;
      item.op    = op;
      item.value = value;
      while ($urandom_range(99) < sender_idle_pct()) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      if (op == OP_LOAD) loaded_values.push_back(value);
      else if (op == OP_CLEAR) loaded_values.delete();
      requests_sent++;
   endtask

   // Mix of wide values, a narrow band for duplicates, the extremes and a middle band.
   function automatic logic signed [VALUE_W-1:0] pick_value();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 40) return $urandom;
      if (roll < 75) return int'($urandom_range(16)) - 8;
      if (roll < 85) begin
         case ($urandom_range(3))
            0:       return VALUE_MIN;
            1:       return VALUE_MAX;
            2:       return 0;
            default: return -1;
         endcase
      end
      return int'($urandom_range(2000)) - 1000;
   endfunction

   // Aim most queries at held values or their neighbours, the rest anywhere.
   function automatic logic signed [VALUE_W-1:0] query_value();
      int unsigned               roll;
      logic signed [VALUE_W-1:0] held;
      roll = $urandom_range(99);
      if (loaded_values.size() == 0 || roll >= 75) return pick_value();
      held = loaded_values[$urandom_range(loaded_values.size() - 1)];
      if (roll < 55) return held;
      return ($urandom_range(1) != 0) ? held + 1 : held - 1;
   endfunction

   // Empty the table, fill it to the brim, push past it, query, then send op code three.
   task automatic fill_table();
      send_request(OP_CLEAR, pick_value());
      repeat (TABLE_DEPTH) send_request(OP_LOAD, pick_value());
      repeat (3) send_request(OP_LOAD, pick_value());
      repeat (20) send_request(OP_QUERY, query_value());
      send_request(OP_SPARE, pick_value());
   endtask

   // Well-formed run: clear, a handful of loads, then mostly queries with a few
   // late loads and ignored op codes mixed in.
   task automatic table_session();
      int loads;
      int queries;
      int unsigned roll;
      loads   = ($urandom_range(9) == 0) ? $urandom_range(20, 48) : $urandom_range(1, 12);
      queries = $urandom_range(loads, 2 * loads + 4);
      send_request(OP_CLEAR, pick_value());
      repeat (loads) send_request(OP_LOAD, pick_value());
      repeat (queries) begin
         roll = $urandom_range(99);
         if (roll < 8)       send_request(OP_SPARE, pick_value());
         else if (roll < 16) send_request(OP_LOAD, pick_value());
         else                send_request(OP_QUERY, query_value());
      end
   endtask

   // Noise: any op code, any value, no clear first.
   task automatic noise_burst();
      logic [1:0] op;
      repeat ($urandom_range(3, 12)) begin
         op = 2'($urandom_range(3));
         // Keep clears rare so the table keeps some content.
         if (op == OP_CLEAR && $urandom_range(3) != 0) op = OP_QUERY;
         send_request(op, (op == OP_QUERY) ? query_value() : pick_value());
      end
   endtask

   initial begin
      int  random_start;
      int  random_done;
      bit  big_fill_done;
      req_type idle_item;
      idle_item.op    = OP_QUERY;
      idle_item.value = '0;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = idle_item;
      big_fill_done = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty table, extremes, duplicates, misses, ignored op, clear.
      send_request(OP_QUERY, 0);
      send_request(OP_SPARE, VALUE_MAX);
      send_request(OP_LOAD, VALUE_MAX);
      send_request(OP_LOAD, VALUE_MIN);
      send_request(OP_LOAD, 0);
      send_request(OP_LOAD, -1);
      send_request(OP_LOAD, 1);
      send_request(OP_LOAD, 0);
      send_request(OP_LOAD, 5);
      send_request(OP_QUERY, VALUE_MAX);
      send_request(OP_QUERY, VALUE_MIN);
      send_request(OP_QUERY, 0);
      send_request(OP_QUERY, 2);
      send_request(OP_QUERY, VALUE_MAX - 1);
      send_request(OP_QUERY, VALUE_MIN + 1);
      send_request(OP_SPARE, -1);
      send_request(OP_CLEAR, 5);
      // Old slots must not be seen once cleared.
      send_request(OP_QUERY, 0);
      send_request(OP_LOAD, 7);
      send_request(OP_QUERY, 7);
      send_request(OP_CLEAR, VALUE_MIN);
      send_request(OP_QUERY, 7);

      // Full table and drops past it.
      fill_table();

      // Random part in three idling phases; one further full fill in the middle one.
      random_start = requests_sent;
      random_done  = 0;
      while (random_done < RANDOM_REQUESTS) begin
         if (random_done < RANDOM_REQUESTS / 3)          idle_mode = IDLE_SENDER_LIGHT;
         else if (random_done < 2 * RANDOM_REQUESTS / 3) idle_mode = IDLE_SENDER_HEAVY;
         else                                            idle_mode = IDLE_NONE;
         if (idle_mode == IDLE_SENDER_HEAVY && !big_fill_done) begin
            fill_table();
            big_fill_done = 1'b1;
         end else if ($urandom_range(99) < 70) begin
            table_session();
         end else begin
            noise_burst();
         end
         random_done = requests_sent - random_start;
      end

      // Repeated hits on a one-entry table, a miss, then clear the hit count.
      idle_mode = IDLE_NONE;
      send_request(OP_CLEAR, 0);
      send_request(OP_LOAD, -42);
      repeat (8) send_request(OP_QUERY, -42);
      send_request(OP_QUERY, 42);
      send_request(OP_SPARE, -42);
      send_request(OP_CLEAR, -42);
      send_request(OP_QUERY, -42);

      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("sorted_table_membership_search_core_tb: PASS");
      end else begin
         $display("sorted_table_membership_search_core_tb: FAIL");
      end
      $finish;
   end

endmodule
